// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the pair phi-star cut.
// Depends on nothing; assertions compile out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== design/ppmc_pkg.sv =====
// Package for the pair phi-star cut: widths, angle constants, CORDIC table.
// Depends on nothing; used by all modules of the block and the testbench.
`default_nettype none

package ppmc_pkg;

    localparam int MOMENTUM_WIDTH  = 20;
    localparam int RADIUS_LIMIT_CM = 1023;

    localparam int PT_W     = MOMENTUM_WIDTH;
    localparam int SQ_IN_W  = (2 * MOMENTUM_WIDTH > 62) ? 2 * MOMENTUM_WIDTH : 62;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int MOP_W    = (MOMENTUM_WIDTH > 31) ? MOMENTUM_WIDTH : 31;
    localparam int CIN_W    = MOP_W + 1;
    localparam int CW       = CIN_W + 27;
    localparam int AW       = 26;
    localparam int ANG_W    = 17;
    localparam int RAD_W    = 10;
    localparam int A_W      = 16;
    localparam int B_W      = PT_W + 2;
    localparam int Q_W      = 31;
    localparam int D_W      = 19;
    localparam int M_W      = 5;

    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int HALF_TURN    = 46080;
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_FINE = 90 * 65536;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_RADIUS = 3'd0;
    localparam logic [2:0] CFG_MAX_RADIUS = 3'd1;
    localparam logic [2:0] CFG_FIELD_SIGN = 3'd2;
    localparam logic [2:0] CFG_CUT_LOW    = 3'd3;
    localparam logic [2:0] CFG_CUT_HIGH   = 3'd4;

    // arctan(2^-i) in 1/65536 degree
    function automatic logic [AW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [AW-1:0] v;
        case (i)
            5'd0:    v = AW'(2949120);
            5'd1:    v = AW'(1740967);
            5'd2:    v = AW'(919879);
            5'd3:    v = AW'(466945);
            5'd4:    v = AW'(234379);
            5'd5:    v = AW'(117304);
            5'd6:    v = AW'(58666);
            5'd7:    v = AW'(29335);
            5'd8:    v = AW'(14668);
            5'd9:    v = AW'(7334);
            5'd10:   v = AW'(3667);
            5'd11:   v = AW'(1833);
            5'd12:   v = AW'(917);
            5'd13:   v = AW'(458);
            5'd14:   v = AW'(229);
            5'd15:   v = AW'(115);
            5'd16:   v = AW'(57);
            5'd17:   v = AW'(29);
            5'd18:   v = AW'(14);
            5'd19:   v = AW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/ppmc_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on ppmc_pkg for widths.
`default_nettype none

module ppmc_isqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ppmc_pkg::SQ_IN_W-1:0] operand,
    output logic                              done,
    output logic [ppmc_pkg::SQ_OUT_W-1:0]     root
);

    localparam int CNT_W = $clog2(ppmc_pkg::SQ_OUT_W + 1);

    logic [ppmc_pkg::SQ_IN_W-1:0] n_reg;
    logic [ppmc_pkg::SQ_IN_W-1:0] r_reg;
    logic [ppmc_pkg::SQ_IN_W-1:0] b_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [ppmc_pkg::SQ_IN_W-1:0] trial;

    assign trial = r_reg + b_reg;

    // Control: run a fixed number of steps, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ppmc_pkg::SQ_OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one result bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= operand;
            r_reg <= '0;
            b_reg <= ppmc_pkg::SQ_IN_W'(1) << (ppmc_pkg::SQ_IN_W - 2);
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ppmc_pkg::SQ_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== design/ppmc_div.sv =====
// Restoring divider for floor(a * 2^30 / b), one quotient bit per cycle.
// Depends on ppmc_pkg; requires a <= b.
`default_nettype none

module ppmc_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [ppmc_pkg::A_W-1:0] dividend,
    input  wire logic [ppmc_pkg::B_W-1:0] divisor,
    output logic                          done,
    output logic [ppmc_pkg::Q_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(ppmc_pkg::Q_W + 1);
    localparam int R_W   = ppmc_pkg::B_W + 1;

    logic [R_W-1:0]              rem_reg;
    logic [ppmc_pkg::B_W-1:0]    b_reg;
    logic [ppmc_pkg::Q_W-1:0]    q_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        ge;
    logic [R_W-1:0]              diff;

    assign ge   = rem_reg >= R_W'(b_reg);
    assign diff = ge ? (rem_reg - R_W'(b_reg)) : rem_reg;

    // Control: count quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ppmc_pkg::Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract, shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= R_W'(dividend);
            b_reg   <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[ppmc_pkg::Q_W-2:0], ge};
            rem_reg <= diff << 1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== design/ppmc_cordic.sv =====
// Vectoring CORDIC for atan2, result rounded to 1/256 degree.
// Depends on ppmc_pkg for widths and the arctangent table.
`default_nettype none

module ppmc_cordic (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ppmc_pkg::CIN_W-1:0] y_in,
    input  wire logic signed [ppmc_pkg::CIN_W-1:0] x_in,
    output logic                                   done,
    output logic signed [ppmc_pkg::ANG_W-1:0]      angle
);

    logic signed [ppmc_pkg::CW-1:0]  x_reg;
    logic signed [ppmc_pkg::CW-1:0]  y_reg;
    logic signed [ppmc_pkg::AW-1:0]  ang_reg;
    logic [ppmc_pkg::STEP_W-1:0]     cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic signed [ppmc_pkg::CW-1:0]  xe;
    logic signed [ppmc_pkg::CW-1:0]  ye;
    logic signed [ppmc_pkg::CW-1:0]  xs;
    logic signed [ppmc_pkg::CW-1:0]  ys;
    logic signed [ppmc_pkg::AW-1:0]  step_ang;
    logic signed [ppmc_pkg::AW-1:0]  rounded;
    logic                            zero_in;

    assign xe       = ppmc_pkg::CW'(x_in) <<< 24;
    assign ye       = ppmc_pkg::CW'(y_in) <<< 24;
    assign zero_in  = (x_in == '0) && (y_in == '0);
    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign step_ang = $signed(ppmc_pkg::atan_entry(cnt_reg));
    assign rounded  = ang_reg + ppmc_pkg::AW'(128);

    // Control: twenty micro-rotations, zero vector finishes at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (zero_in)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ppmc_pkg::STEP_W'(ppmc_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: fold left half-plane, then rotate toward the x axis
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (zero_in)
            begin
                x_reg   <= xe;
                y_reg   <= ye;
                ang_reg <= '0;
            end
            else if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    x_reg   <= ye;
                    y_reg   <= -xe;
                    ang_reg <= ppmc_pkg::AW'(ppmc_pkg::QUARTER_FINE);
                end
                else
                begin
                    x_reg   <= -ye;
                    y_reg   <= xe;
                    ang_reg <= -ppmc_pkg::AW'(ppmc_pkg::QUARTER_FINE);
                end
            end
            else
            begin
                x_reg   <= xe;
                y_reg   <= ye;
                ang_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                ang_reg <= ang_reg + step_ang;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                ang_reg <= ang_reg - step_ang;
            end
        end
    end

    assign done  = done_reg;
    assign angle = rounded[ppmc_pkg::ANG_W+7:8];

endmodule

`default_nettype wire

// ===== design/pair_phistar_min_cut.sv =====
// Pair phi-star cut: sequencer around one square-root, divider and CORDIC unit.
// Flow: pt and phi of both tracks first, then for each radius scanned a divide,
// square root and CORDIC per track; a radius at which either track has no
// bend angle is skipped.
// One item at a time: in_stall is high from acceptance until the result loads.
// Reset (rst_n low, asynchronous) clears control and restores the configuration registers.
`default_nettype none
`include "assert_macros.svh"

module pair_phistar_min_cut (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       cfg_write,
    input  wire logic [2:0]                                 cfg_index,
    input  wire logic [16:0]                                cfg_data,
    input  wire logic                                       in_valid,
    output logic                                            in_stall,
    input  wire logic signed [ppmc_pkg::MOMENTUM_WIDTH-1:0] first_px,
    input  wire logic signed [ppmc_pkg::MOMENTUM_WIDTH-1:0] first_py,
    input  wire logic signed [2:0]                          first_charge,
    input  wire logic signed [ppmc_pkg::MOMENTUM_WIDTH-1:0] second_px,
    input  wire logic signed [ppmc_pkg::MOMENTUM_WIDTH-1:0] second_py,
    input  wire logic signed [2:0]                          second_charge,
    output logic                                            out_valid,
    input  wire logic                                       out_stall,
    output logic signed [16:0]                              min_dphi,
    output logic                                            found_any,
    output logic                                            pair_passes
);

    localparam int MW = ppmc_pkg::MOMENTUM_WIDTH;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_PT_MX  = 15'b000000000000010,
        S_PT_MY  = 15'b000000000000100,
        S_PT_ADD = 15'b000000000001000,
        S_PT_SQ  = 15'b000000000010000,
        S_PHI    = 15'b000000000100000,
        S_RCHK   = 15'b000000001000000,
        S_BEND   = 15'b000000010000000,
        S_DIV    = 15'b000000100000000,
        S_SSQ    = 15'b000001000000000,
        S_CSQ    = 15'b000010000000000,
        S_ASQ    = 15'b000100000000000,
        S_ASN    = 15'b001000000000000,
        S_ACC    = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [ppmc_pkg::RAD_W-1:0]        min_radius_reg;
    logic [ppmc_pkg::RAD_W-1:0]        max_radius_reg;
    logic signed [1:0]                 field_sign_reg;
    logic signed [16:0]                cut_low_reg;
    logic signed [16:0]                cut_high_reg;

    // Item state
    logic signed [MW-1:0]              px_reg [2];
    logic signed [MW-1:0]              py_reg [2];
    logic signed [ppmc_pkg::M_W-1:0]   m_reg [2];
    logic [ppmc_pkg::PT_W-1:0]         pt_reg [2];
    logic signed [ppmc_pkg::ANG_W-1:0] phi_reg [2];
    logic signed [ppmc_pkg::ANG_W-1:0] t_reg [2];
    logic                              trk_reg;
    logic [ppmc_pkg::RAD_W-1:0]        r_reg;
    logic [ppmc_pkg::Q_W-1:0]          s_reg;
    logic [ppmc_pkg::SQ_IN_W-1:0]      mul_reg;
    logic [ppmc_pkg::SQ_IN_W-1:0]      acc_reg;
    logic signed [16:0]                best_reg;
    logic [16:0]                       best_abs_reg;
    logic                              found_reg;

    // Output register
    logic                              out_valid_reg;
    logic signed [16:0]                phistar_reg;
    logic                              found_out_reg;
    logic                              pass_reg;

    // Unit handshakes
    logic                              sq_start;
    logic [ppmc_pkg::SQ_IN_W-1:0]      sq_operand;
    logic                              sq_done;
    logic [ppmc_pkg::SQ_OUT_W-1:0]     sq_root;
    logic                              div_start;
    logic                              div_done;
    logic [ppmc_pkg::Q_W-1:0]          div_q;
    logic                              cor_start;
    logic signed [ppmc_pkg::CIN_W-1:0] cor_y;
    logic signed [ppmc_pkg::CIN_W-1:0] cor_x;
    logic                              cor_done;
    logic signed [ppmc_pkg::ANG_W-1:0] cor_angle;

    // Shared multiplier operands
    logic [ppmc_pkg::MOP_W-1:0]        mul_op;
    logic [MW-1:0]                     ax_sel;
    logic [MW-1:0]                     ay_sel;

    // Bend term quantities
    logic signed [ppmc_pkg::M_W-1:0]   m_sel;
    logic [ppmc_pkg::M_W-1:0]          abs_m;
    logic [ppmc_pkg::A_W-1:0]          a_val;
    logic [ppmc_pkg::B_W-1:0]          b_val;
    logic                              skip;
    logic                              scan_on;
    logic signed [ppmc_pkg::ANG_W-1:0] bend_ang;

    // Accumulate quantities
    logic signed [ppmc_pkg::D_W-1:0]   d_raw;
    logic signed [ppmc_pkg::D_W-1:0]   d_w1;
    logic signed [ppmc_pkg::D_W-1:0]   d_w2;
    logic signed [ppmc_pkg::D_W-1:0]   d_w3;
    logic signed [ppmc_pkg::D_W-1:0]   d_wrap;
    logic [16:0]                       d_abs;
    logic                              take;
    logic                              pass_now;
    logic                              in_accept;
    logic                              out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Track-selected operands
    assign ax_sel = px_reg[trk_reg] < 0 ? MW'(-px_reg[trk_reg]) : MW'(px_reg[trk_reg]);
    assign ay_sel = py_reg[trk_reg] < 0 ? MW'(-py_reg[trk_reg]) : MW'(py_reg[trk_reg]);
    assign m_sel  = m_reg[trk_reg];
    assign abs_m  = m_sel < 0 ? ppmc_pkg::M_W'(-m_sel) : ppmc_pkg::M_W'(m_sel);
    assign a_val  = ppmc_pkg::A_W'(3) * ppmc_pkg::A_W'(abs_m) * ppmc_pkg::A_W'(r_reg);
    assign b_val  = {pt_reg[trk_reg], 2'b00};
    assign skip   = (pt_reg[trk_reg] == '0)
                 || (40'(a_val) > 40'(b_val));
    assign scan_on = (r_reg < max_radius_reg)
                  && (32'(r_reg) <= 32'(ppmc_pkg::RADIUS_LIMIT_CM));
    assign bend_ang = (m_sel > 0) ? -cor_angle : cor_angle;

    always_comb
    begin
        case (state_reg)
            S_PT_MX: mul_op = ppmc_pkg::MOP_W'(ax_sel);
            S_PT_MY: mul_op = ppmc_pkg::MOP_W'(ay_sel);
            S_SSQ:   mul_op = ppmc_pkg::MOP_W'(s_reg);
            default: mul_op = '0;
        endcase
    end

    // Wrap the difference into (-180, 180] degrees
    assign d_raw  = ppmc_pkg::D_W'(phi_reg[1]) - ppmc_pkg::D_W'(phi_reg[0])
                  + ppmc_pkg::D_W'(t_reg[1]) - ppmc_pkg::D_W'(t_reg[0]);
    assign d_w1   = (d_raw > ppmc_pkg::D_W'(ppmc_pkg::HALF_TURN))
                  ? d_raw - ppmc_pkg::D_W'(ppmc_pkg::FULL_TURN) : d_raw;
    assign d_w2   = (d_w1 > ppmc_pkg::D_W'(ppmc_pkg::HALF_TURN))
                  ? d_w1 - ppmc_pkg::D_W'(ppmc_pkg::FULL_TURN) : d_w1;
    assign d_w3   = (d_w2 <= -ppmc_pkg::D_W'(ppmc_pkg::HALF_TURN))
                  ? d_w2 + ppmc_pkg::D_W'(ppmc_pkg::FULL_TURN) : d_w2;
    assign d_wrap = (d_w3 <= -ppmc_pkg::D_W'(ppmc_pkg::HALF_TURN))
                  ? d_w3 + ppmc_pkg::D_W'(ppmc_pkg::FULL_TURN) : d_w3;
    assign d_abs  = d_wrap < 0 ? 17'(-d_wrap) : 17'(d_wrap);
    assign take   = !found_reg || (d_abs < best_abs_reg);
    assign pass_now = !found_reg || (best_reg <= cut_low_reg) || (best_reg >= cut_high_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        sq_operand = '0;
        div_start  = 1'b0;
        cor_start  = 1'b0;
        cor_y      = '0;
        cor_x      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PT_MX;
                end
            end
            S_PT_MX:
            begin
                state_next = S_PT_MY;
            end
            S_PT_MY:
            begin
                state_next = S_PT_ADD;
            end
            S_PT_ADD:
            begin
                sq_start   = 1'b1;
                sq_operand = acc_reg + mul_reg;
                state_next = S_PT_SQ;
            end
            S_PT_SQ:
            begin
                if (sq_done)
                begin
                    cor_start  = 1'b1;
                    cor_y      = ppmc_pkg::CIN_W'(py_reg[trk_reg]);
                    cor_x      = ppmc_pkg::CIN_W'(px_reg[trk_reg]);
                    state_next = S_PHI;
                end
            end
            S_PHI:
            begin
                if (cor_done)
                begin
                    state_next = trk_reg ? S_RCHK : S_PT_MX;
                end
            end
            S_RCHK:
            begin
                state_next = scan_on ? S_BEND : S_DONE;
            end
            S_BEND:
            begin
                if (skip)
                begin
                    state_next = S_RCHK;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SSQ;
                end
            end
            S_SSQ:
            begin
                state_next = S_CSQ;
            end
            S_CSQ:
            begin
                sq_start   = 1'b1;
                sq_operand = (ppmc_pkg::SQ_IN_W'(1) << 60) - mul_reg;
                state_next = S_ASQ;
            end
            S_ASQ:
            begin
                if (sq_done)
                begin
                    cor_start  = 1'b1;
                    cor_y      = ppmc_pkg::CIN_W'(s_reg);
                    cor_x      = ppmc_pkg::CIN_W'(sq_root);
                    state_next = S_ASN;
                end
            end
            S_ASN:
            begin
                if (cor_done)
                begin
                    state_next = trk_reg ? S_ACC : S_BEND;
                end
            end
            S_ACC:
            begin
                state_next = S_RCHK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            trk_reg        <= 1'b0;
            min_radius_reg <= ppmc_pkg::RAD_W'(34);
            max_radius_reg <= ppmc_pkg::RAD_W'(133);
            field_sign_reg <= 2'sd1;
            cut_low_reg    <= '0;
            cut_high_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    ppmc_pkg::CFG_MIN_RADIUS: min_radius_reg <= cfg_data[ppmc_pkg::RAD_W-1:0];
                    ppmc_pkg::CFG_MAX_RADIUS: max_radius_reg <= cfg_data[ppmc_pkg::RAD_W-1:0];
                    ppmc_pkg::CFG_FIELD_SIGN: field_sign_reg <= cfg_data[1:0];
                    ppmc_pkg::CFG_CUT_LOW:    cut_low_reg    <= cfg_data;
                    ppmc_pkg::CFG_CUT_HIGH:   cut_high_reg   <= cfg_data;
                    default:                  ;
                endcase
            end
            // Drop the result once taken, load a new one when done
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // Advance the track index
            if (in_accept)
            begin
                trk_reg <= 1'b0;
            end
            else if ((state_reg == S_PHI || state_reg == S_ASN) && cor_done)
            begin
                trk_reg <= ~trk_reg;
            end
            else if (state_reg == S_BEND && skip)
            begin
                trk_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg[0] <= first_px;
            py_reg[0] <= first_py;
            px_reg[1] <= second_px;
            py_reg[1] <= second_py;
            m_reg[0]  <= ppmc_pkg::M_W'(first_charge) * ppmc_pkg::M_W'(field_sign_reg);
            m_reg[1]  <= ppmc_pkg::M_W'(second_charge) * ppmc_pkg::M_W'(field_sign_reg);
        end
        mul_reg <= ppmc_pkg::SQ_IN_W'(mul_op * mul_op);
        if (state_reg == S_PT_MY)
        begin
            acc_reg <= mul_reg;
        end
        if (state_reg == S_PT_SQ && sq_done)
        begin
            pt_reg[trk_reg] <= sq_root[ppmc_pkg::PT_W-1:0];
        end
        if (state_reg == S_PHI && cor_done)
        begin
            phi_reg[trk_reg] <= cor_angle;
            if (trk_reg)
            begin
                r_reg        <= min_radius_reg;
                found_reg    <= 1'b0;
                best_reg     <= '0;
                best_abs_reg <= '0;
            end
        end
        if (state_reg == S_BEND && skip)
        begin
            r_reg <= r_reg + 1'b1;
        end
        if (state_reg == S_DIV && div_done)
        begin
            s_reg <= div_q;
        end
        if (state_reg == S_ASN && cor_done)
        begin
            t_reg[trk_reg] <= bend_ang;
        end
        // Keep the smallest magnitude, first one on a tie
        if (state_reg == S_ACC)
        begin
            r_reg <= r_reg + 1'b1;
            if (take)
            begin
                best_reg     <= d_wrap[16:0];
                best_abs_reg <= d_abs;
                found_reg    <= 1'b1;
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            phistar_reg   <= best_reg;
            found_out_reg <= found_reg;
            pass_reg      <= pass_now;
        end
    end

    ppmc_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .root    (sq_root)
    );

    ppmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_val),
        .divisor  (b_val),
        .done     (div_done),
        .quotient (div_q)
    );

    ppmc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    assign out_valid   = out_valid_reg;
    assign min_dphi    = phistar_reg;
    assign found_any   = found_out_reg;
    assign pair_passes = pass_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)
    `ASSERT_IMPL(a_none_passes, clk, rst_n, out_valid && !found_any, pair_passes)
    `ASSERT_IMPL(a_none_zero, clk, rst_n, out_valid && !found_any, min_dphi == 17'sd0)
    `ASSERT_IMPL(a_min_range, clk, rst_n, out_valid,
                 (min_dphi <= 17'sd46080) && (min_dphi > -17'sd46080))

endmodule

`default_nettype wire

// ===== tb/sv/pair_phistar_min_cut_tb.sv =====
// Testbench for the pair phi-star minimum cut: directed and random track pairs.
// Depends on ppmc_pkg and pair_phistar_min_cut; predicts each result itself.
`timescale 1ns / 100ps
`default_nettype none

module pair_phistar_min_cut_tb;

    localparam int  MW          = ppmc_pkg::MOMENTUM_WIDTH;
    localparam int  CYCLE_LIMIT = 8_000_000;
    localparam int  SETTLE      = 300;

    typedef struct {
        logic signed [MW-1:0] px1;
        logic signed [MW-1:0] py1;
        logic signed [2:0]    q1;
        logic signed [MW-1:0] px2;
        logic signed [MW-1:0] py2;
        logic signed [2:0]    q2;
    } track_pair_t;

    typedef struct {
        logic signed [16:0] phistar;
        logic               found;
        logic               passes;
    } cut_verdict_t;

    // arctan(2^-i) in 1/65536 degree
    localparam longint ARCTAN_FINE [ppmc_pkg::CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [2:0]           cfg_index;
    logic [16:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [MW-1:0] first_px;
    logic signed [MW-1:0] first_py;
    logic signed [2:0]    first_charge;
    logic signed [MW-1:0] second_px;
    logic signed [MW-1:0] second_py;
    logic signed [2:0]    second_charge;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [16:0]   min_dphi;
    logic                 found_any;
    logic                 pair_passes;

    // mirror of the block's registers
    logic [9:0]           scan_first;
    logic [9:0]           scan_stop;
    logic signed [1:0]    field_mult;
    logic signed [16:0]   bound_low;
    logic signed [16:0]   bound_high;

    cut_verdict_t         pending_verdicts[$];
    int                   error_count;
    int                   cycle_count;
    bit                   quiet;

    pair_phistar_min_cut dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_px(first_px), .first_py(first_py), .first_charge(first_charge),
        .second_px(second_px), .second_py(second_py), .second_charge(second_charge),
        .out_valid(out_valid), .out_stall(out_stall),
        .min_dphi(min_dphi), .found_any(found_any), .pair_passes(pair_passes)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // atan2 in 1/256 degree by vectoring CORDIC, rounded half up
    function automatic longint heading(input longint y, input longint x);
        longint ang;
        longint t;
        longint xs;
        longint ys;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * (64'sd1 <<< 24);
        y = y * (64'sd1 <<< 24);
        // fold the left half plane onto the right
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; ang = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < ppmc_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; ang = ang + ARCTAN_FINE[i];
            end
            else
            begin
                x = x - ys; y = y + xs; ang = ang - ARCTAN_FINE[i];
            end
        end
        return (ang + 128) >>> 8;
    endfunction

    // bending angle asin(-0.75*m*r/pt); zero return when undefined
    function automatic bit bend_angle(input longint m, input longint unsigned r,
                                      input longint unsigned pt, output longint ang);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned s;
        longint unsigned c;
        ang = 0;
        if (pt == 0)
            return 1'b0;
        mag = (m < 0) ? longint'(-m) : longint'(m);
        num = 3 * mag * r;
        den = 4 * pt;
        if (num > den)
            return 1'b0;
        s = (num << 30) / den;
        c = int_sqrt((64'd1 << 60) - s * s);
        ang = heading(longint'(s), longint'(c));
        if (m > 0)
            ang = -ang;
        return 1'b1;
    endfunction

    function automatic longint unsigned transverse(input longint px, input longint py);
        longint unsigned ax;
        longint unsigned ay;
        ax = (px < 0) ? longint'(-px) : longint'(px);
        ay = (py < 0) ? longint'(-py) : longint'(py);
        return int_sqrt(ax * ax + ay * ay);
    endfunction

    function automatic cut_verdict_t predict_cut(input track_pair_t p);
        cut_verdict_t v;
        longint unsigned pt1;
        longint unsigned pt2;
        longint phi1;
        longint phi2;
        longint m1;
        longint m2;
        longint bend1;
        longint bend2;
        longint d;
        longint ad;
        longint best;
        longint best_abs;
        bit found;
        pt1 = transverse(longint'(p.px1), longint'(p.py1));
        pt2 = transverse(longint'(p.px2), longint'(p.py2));
        phi1 = heading(longint'(p.py1), longint'(p.px1));
        phi2 = heading(longint'(p.py2), longint'(p.px2));
        m1 = longint'(p.q1) * longint'(field_mult);
        m2 = longint'(p.q2) * longint'(field_mult);
        best = 0;
        best_abs = 0;
        found = 1'b0;
        // scan radii, keep the first value of smallest magnitude
        for (longint unsigned r = scan_first;
             r < scan_stop && r <= ppmc_pkg::RADIUS_LIMIT_CM; r++)
        begin
            if (!bend_angle(m1, r, pt1, bend1))
                continue;
            if (!bend_angle(m2, r, pt2, bend2))
                continue;
            d = phi2 - phi1 + bend2 - bend1;
            while (d > ppmc_pkg::HALF_TURN)
                d = d - ppmc_pkg::FULL_TURN;
            while (d <= -ppmc_pkg::HALF_TURN)
                d = d + ppmc_pkg::FULL_TURN;
            ad = (d < 0) ? -d : d;
            if (!found || ad < best_abs)
            begin
                best = d;
                best_abs = ad;
                found = 1'b1;
            end
        end
        v.phistar = best[16:0];
        v.found = found;
        v.passes = !found || best <= longint'(bound_low) || best >= longint'(bound_high);
        return v;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        cut_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
                flag_mismatch("result with no prediction waiting");
            else
            begin
                want = pending_verdicts.pop_front();
                if (min_dphi !== want.phistar)
                    flag_mismatch($sformatf("min_dphi %0d, predicted %0d",
                                            min_dphi, want.phistar));
                if (found_any !== want.found)
                    flag_mismatch($sformatf("found_any %0b, predicted %0b",
                                            found_any, want.found));
                if (pair_passes !== want.passes)
                    flag_mismatch($sformatf("pair_passes %0b, predicted %0b",
                                            pair_passes, want.passes));
            end
        end
    end

    // stall the result side in bursts
    always @(posedge clk)
    begin
        int hold_left;
        if (quiet)
            out_stall <= 1'b0;
        else if (hold_left > 0)
            hold_left--;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            hold_left = $urandom_range(0, 11);
        end
        else
        begin
            out_stall <= 1'b0;
            hold_left = $urandom_range(0, 30);
        end
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("pair_phistar_min_cut_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic track_pair_t make_pair(input int px1, input int py1, input int q1,
                                              input int px2, input int py2, input int q2);
        track_pair_t p;
        p.px1 = MW'(px1); p.py1 = MW'(py1); p.q1 = 3'(q1);
        p.px2 = MW'(px2); p.py2 = MW'(py2); p.q2 = 3'(q2);
        return p;
    endfunction

    // hold the item until accepted, then predict its result
    task automatic send_pair(input track_pair_t p);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        first_px      <= p.px1;
        first_py      <= p.py1;
        first_charge  <= p.q1;
        second_px     <= p.px2;
        second_py     <= p.py2;
        second_charge <= p.q2;
        do
            @(posedge clk);
        while (in_stall);
        pending_verdicts.push_back(predict_cut(p));
    endtask

    // drop valid and wait for every result
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            ppmc_pkg::CFG_MIN_RADIUS: scan_first = value[9:0];
            ppmc_pkg::CFG_MAX_RADIUS: scan_stop  = value[9:0];
            ppmc_pkg::CFG_FIELD_SIGN: field_mult = value[1:0];
            ppmc_pkg::CFG_CUT_LOW:    bound_low  = value;
            ppmc_pkg::CFG_CUT_HIGH:   bound_high = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input int rmin, input int rmax, input int fs,
                                input int lo, input int hi);
        drain();
        write_reg(ppmc_pkg::CFG_MIN_RADIUS, 17'(rmin));
        write_reg(ppmc_pkg::CFG_MAX_RADIUS, 17'(rmax));
        write_reg(ppmc_pkg::CFG_FIELD_SIGN, 17'(fs));
        write_reg(ppmc_pkg::CFG_CUT_LOW, 17'(lo));
        write_reg(ppmc_pkg::CFG_CUT_HIGH, 17'(hi));
        cfg_write <= 1'b0;
    endtask

    // momentum component of random scale, so both tiny and huge pt occur
    function automatic logic signed [MW-1:0] random_momentum(input int min_shift);
        logic signed [MW-1:0] raw;
        raw = MW'($urandom);
        return raw >>> $urandom_range(0, MW - 1 - min_shift);
    endfunction

    function automatic int random_charge(input bit any);
        if (any)
            return $urandom_range(0, 7);
        return $urandom_range(0, 4) - 2;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_registers;
        send_pair(make_pair(1200, 300, 1, 900, -250, -1));
        send_pair(make_pair(-5000, 4000, -2, 3000, 2500, 2));
    endtask

    task automatic test_momentum_extremes;
        apply_config(34, 40, 1, 0, 0);
        send_pair(make_pair(524287, -524288, 1, -524288, -524288, -1));
        send_pair(make_pair(524287, 524287, 2, -524288, 524287, -2));
        send_pair(make_pair(0, 0, 1, 0, 0, 1));
        send_pair(make_pair(0, 0, 1, 800, 600, 1));
        send_pair(make_pair(10, 5, 2, 400, -30, 1));
        send_pair(make_pair(-1, 0, 0, 0, -1, 0));
    endtask

    task automatic test_charges_and_field;
        apply_config(20, 26, -2, -500, 500);
        send_pair(make_pair(2000, 1000, -4, -1500, 700, 3));
        send_pair(make_pair(-900, -2500, 3, 1800, -1700, -4));
        apply_config(20, 24, 0, -500, 500);
        send_pair(make_pair(2000, 1000, 2, 2100, 900, -2));
        apply_config(20, 24, -1, -500, 500);
        send_pair(make_pair(2000, 1000, 1, 2100, 900, -1));
    endtask

    task automatic test_scan_edges;
        apply_config(0, 3, 1, 0, 0);
        send_pair(make_pair(300, 400, 1, -300, 400, -1));
        apply_config(1023, 1023, 1, 0, 0);
        send_pair(make_pair(300, 400, 1, -300, 400, -1));
        apply_config(100, 50, 1, 0, 0);
        send_pair(make_pair(300, 400, 1, -300, 400, -1));
        apply_config(1017, 1023, 1, 0, 0);
        send_pair(make_pair(9000, 100, 1, -9000, 300, 2));
    endtask

    task automatic test_cut_bounds;
        apply_config(40, 44, 1, -46080, 46080);
        send_pair(make_pair(1000, 0, 1, -1000, 10, 1));
        send_pair(make_pair(1000, 0, 1, 1000, 20, 1));
        apply_config(40, 44, 1, 46080, -46080);
        send_pair(make_pair(1000, 0, 1, 0, 1000, -1));
        apply_config(40, 44, 1, 600, 600);
        send_pair(make_pair(1000, 0, 1, 990, 10, 1));
    endtask

    task automatic test_random_pairs;
        int rmin;
        int span;
        int fs;
        int lo;
        int hi;
        track_pair_t p;
        for (int phase = 0; phase < 12; phase++)
        begin
            // short scans for most phases, one near the top radius
            span = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            rmin = (phase == 5) ? 1023 - span : $urandom_range(0, 400);
            fs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : (($urandom_range(0, 1) != 0) ? 1 : 3);
            lo = $urandom_range(0, 92160) - 46080;
            hi = $urandom_range(0, 92160) - 46080;
            if (phase >= 10)
                quiet = 1'b1;
            apply_config(rmin, rmin + span, fs, lo, hi);
            for (int k = 0; k < 20; k++)
            begin
                // mostly tracks with enough pt to bend, the rest noise
                if ($urandom_range(0, 9) < 7)
                begin
                    p.px1 = random_momentum(9);
                    p.py1 = random_momentum(9);
                    p.px2 = random_momentum(9);
                    p.py2 = random_momentum(9);
                    p.q1 = 3'(random_charge(1'b0));
                    p.q2 = 3'(random_charge(1'b0));
                end
                else
                begin
                    p.px1 = random_momentum(0);
                    p.py1 = random_momentum(0);
                    p.px2 = random_momentum(0);
                    p.py2 = random_momentum(0);
                    p.q1 = 3'(random_charge(1'b1));
                    p.q2 = 3'(random_charge(1'b1));
                end
                send_pair(p);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        first_px      = '0;
        first_py      = '0;
        first_charge  = '0;
        second_px     = '0;
        second_py     = '0;
        second_charge = '0;
        error_count   = 0;
        cycle_count   = 0;
        quiet         = 1'b0;
        scan_first    = 10'd34;
        scan_stop     = 10'd133;
        field_mult    = 2'sd1;
        bound_low     = '0;
        bound_high    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_momentum_extremes();
        test_charges_and_field();
        test_scan_edges();
        test_cut_bounds();
        test_random_pairs();
        drain();

        if (error_count == 0)
            $display("pair_phistar_min_cut_tb: clean");
        else
            $display("pair_phistar_min_cut_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
